@@ design/nnta_pkg.sv @@
package nnta_pkg;

  localparam int MAX_TRACKS = 32;
  localparam int MAX_DETS   = 16;
  localparam int TRK_AW     = $clog2(MAX_TRACKS);
  localparam int DET_AW     = $clog2(MAX_DETS);
  localparam int TRK_CW     = $clog2(MAX_TRACKS + 1);
  localparam int DET_CW     = $clog2(MAX_DETS + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_GATE    = 2'd0;
  localparam logic [1:0] CFG_MOTION  = 2'd1;
  localparam logic [1:0] CFG_CONFIRM = 2'd2;
  localparam logic [1:0] CFG_MISSED  = 2'd3;

  // request kinds
  localparam logic REQ_DET = 1'b0;
  localparam logic REQ_END = 1'b1;

  typedef struct packed {
    logic [15:0] ident;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  count;
    logic [31:0] last_seen;
    logic        confirmed;
  } track_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } det_t;

endpackage

@@ design/nnta_if.sv @@
interface nnta_req_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] det_x;
  logic [15:0] det_y;

  modport source (output valid, req_type, det_x, det_y, input ready);
  modport sink (input valid, req_type, det_x, det_y, output ready);
endinterface

interface nnta_res_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [31:0] frame_number;
  logic        has_track;
  logic [15:0] target_id;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] confirmed_total;
  logic        last_of_frame;

  modport source (output valid, frame_number, has_track, target_id, pos_x, pos_y,
                  confirmed_total, last_of_frame, input ready);
  modport sink (input valid, frame_number, has_track, target_id, pos_x, pos_y,
                confirmed_total, last_of_frame, output ready);
endinterface

@@ design/nnta_ram.sv @@
module nnta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/nearest_neighbor_track_associator_top.sv @@
// Detection beats are taken one per cycle while the block is idle, with no result.
// A frame-end beat runs the association over n tracks and m buffered detections;
// output stalls hold it. It uses the single shared 16x16 multiplier for distances
// and the one read port of each memory.
// Synchronous active-high reset clears the control state, counters and valid bits;
// the track and detection memories are not cleared.
module nearest_neighbor_track_associator_top (
  input  logic        clk,
  input  logic        rst,
  nnta_req_if.sink    req,
  nnta_res_if.source  res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_T_RD  = 4'd2;
  localparam logic [3:0] ST_T_LAT = 4'd3;
  localparam logic [3:0] ST_D_RD  = 4'd4;
  localparam logic [3:0] ST_D_DIF = 4'd5;
  localparam logic [3:0] ST_D_MX  = 4'd6;
  localparam logic [3:0] ST_D_MY  = 4'd7;
  localparam logic [3:0] ST_D_CMP = 4'd8;
  localparam logic [3:0] ST_T_END = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;
  localparam logic [3:0] ST_N_RD  = 4'd11;
  localparam logic [3:0] ST_N_WR  = 4'd12;
  localparam logic [3:0] ST_X_RD  = 4'd13;
  localparam logic [3:0] ST_X_CHK = 4'd14;
  localparam logic [3:0] ST_CLOSE = 4'd15;

  logic [3:0] state;

  // configuration
  logic [9:0]  gate_distance;
  logic [9:0]  min_motion;
  logic [7:0]  confirm_frames;
  logic [15:0] max_missed;

  // frame and table bookkeeping
  logic [31:0] frame_counter;
  logic [15:0] next_ident;
  logic [15:0] confirmed_count;
  logic [nnta_pkg::TRK_CW-1:0] num_tracks;
  logic [nnta_pkg::DET_CW-1:0] det_fill;
  logic [nnta_pkg::MAX_DETS-1:0] det_used;

  // association working registers
  logic [nnta_pkg::TRK_CW-1:0] t_idx;
  logic [nnta_pkg::TRK_CW-1:0] w_idx;
  logic [nnta_pkg::DET_CW-1:0] d_idx;
  logic [27:0] gate_sq;
  logic [19:0] motion_sq;
  nnta_pkg::track_t trk;
  logic [15:0] cand_x, cand_y;
  logic [15:0] dx, dy;
  logic [31:0] sq_x, sq_y;
  logic        found;
  logic [nnta_pkg::DET_AW-1:0] best;
  logic [32:0] best_d;
  logic [15:0] best_x, best_y;
  nnta_pkg::track_t upd;

  // output register
  logic        out_valid;
  logic [31:0] out_frame;
  logic        out_has;
  logic [15:0] out_id, out_x, out_y, out_total;
  logic        out_last;

  // memories
  logic                        trk_we;
  logic [nnta_pkg::TRK_AW-1:0] trk_waddr, trk_raddr;
  nnta_pkg::track_t            trk_wdata, trk_rdata;
  logic                        det_we;
  logic [nnta_pkg::DET_AW-1:0] det_raddr;
  nnta_pkg::det_t              det_wdata, det_rdata;

  // combinational helpers
  logic [31:0] mul_out;
  logic [15:0] mul_op;
  logic [32:0] sum_sq;
  logic [7:0]  cnt_inc;
  logic        emit_now;
  logic        out_free;
  logic        out_load;
  logic [31:0] age;
  logic        req_fire;

  nnta_ram #(.WIDTH($bits(nnta_pkg::track_t)), .DEPTH(nnta_pkg::MAX_TRACKS)) u_trk_ram (
    .clk   (clk),
    .we    (trk_we),
    .waddr (trk_waddr),
    .wdata (trk_wdata),
    .raddr (trk_raddr),
    .rdata (trk_rdata)
  );

  nnta_ram #(.WIDTH($bits(nnta_pkg::det_t)), .DEPTH(nnta_pkg::MAX_DETS)) u_det_ram (
    .clk   (clk),
    .we    (det_we),
    .waddr (det_fill[nnta_pkg::DET_AW-1:0]),
    .wdata (det_wdata),
    .raddr (det_raddr),
    .rdata (det_rdata)
  );

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign out_load  = ((state == ST_EMIT) || (state == ST_CLOSE)) && out_free;

  // shared multiplier: dx squared, then dy squared
  assign mul_op  = (state == ST_D_MX) ? dx : dy;
  assign mul_out = mul_op * mul_op;
  assign sum_sq  = {1'b0, sq_x} + {1'b0, sq_y};
  assign cnt_inc = (trk.count == 8'hFF) ? trk.count : trk.count + 8'd1;
  assign emit_now = (cnt_inc > confirm_frames) || trk.confirmed;
  assign age      = frame_counter - trk_rdata.last_seen;

  // updated track entry
  always_comb begin
    upd           = trk;
    upd.x         = best_x;
    upd.y         = best_y;
    upd.last_seen = frame_counter;
    upd.count     = cnt_inc;
    upd.confirmed = emit_now;
  end

  // detection memory write while loading
  assign det_we    = req_fire && (req.req_type == nnta_pkg::REQ_DET)
                     && (det_fill < nnta_pkg::DET_CW'(nnta_pkg::MAX_DETS));
  assign det_wdata = '{x: req.det_x, y: req.det_y};
  assign det_raddr = d_idx[nnta_pkg::DET_AW-1:0];

  // track memory port steering
  always_comb begin
    trk_raddr = t_idx[nnta_pkg::TRK_AW-1:0];
    trk_we    = 1'b0;
    trk_waddr = t_idx[nnta_pkg::TRK_AW-1:0];
    trk_wdata = upd;
    case (state)
      ST_T_END: begin
        trk_we = found && (best_d < {5'd0, gate_sq}) && (best_d >= {13'd0, motion_sq});
      end
      ST_N_WR: begin
        trk_we    = 1'b1;
        trk_waddr = num_tracks[nnta_pkg::TRK_AW-1:0];
        trk_wdata = '{ident: next_ident, x: det_rdata.x, y: det_rdata.y, count: 8'd1,
                      last_seen: frame_counter, confirmed: 1'b0};
      end
      ST_X_CHK: begin
        trk_we    = (age <= {16'd0, max_missed});
        trk_waddr = w_idx[nnta_pkg::TRK_AW-1:0];
        trk_wdata = trk_rdata;
      end
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_distance  <= 10'd160;
      min_motion     <= 10'd32;
      confirm_frames <= 8'd5;
      max_missed     <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nnta_pkg::CFG_GATE:    gate_distance  <= cfg_data[9:0];
        nnta_pkg::CFG_MOTION:  min_motion     <= cfg_data[9:0];
        nnta_pkg::CFG_CONFIRM: confirm_frames <= cfg_data[7:0];
        nnta_pkg::CFG_MISSED:  max_missed     <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      ST_START: begin
        gate_sq   <= {gate_distance, 4'd0} * {gate_distance, 4'd0};
        motion_sq <= min_motion * min_motion;
      end
      ST_T_LAT: trk <= trk_rdata;
      ST_D_DIF: begin
        cand_x <= det_rdata.x;
        cand_y <= det_rdata.y;
        dx <= (trk.x > det_rdata.x) ? trk.x - det_rdata.x : det_rdata.x - trk.x;
        dy <= (trk.y > det_rdata.y) ? trk.y - det_rdata.y : det_rdata.y - trk.y;
      end
      ST_D_MX: sq_x <= mul_out;
      ST_D_MY: sq_y <= mul_out;
      ST_D_CMP: begin
        if (!found || sum_sq < best_d) begin
          best   <= d_idx[nnta_pkg::DET_AW-1:0];
          best_d <= sum_sq;
          best_x <= cand_x;
          best_y <= cand_y;
        end
      end
      default: ;
    endcase
  end

  // output valid: load a new beat, else drop a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      frame_counter   <= '0;
      next_ident      <= 16'd1;
      confirmed_count <= '0;
      num_tracks      <= '0;
      det_fill        <= '0;
      det_used        <= '0;
      t_idx           <= '0;
      w_idx           <= '0;
      d_idx           <= '0;
      found           <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            if (req.req_type == nnta_pkg::REQ_END) begin
              frame_counter <= frame_counter + 32'd1;
              state         <= ST_START;
            end else if (det_we) begin
              det_fill <= det_fill + 1'b1;
            end
          end
        end
        ST_START: begin
          t_idx <= '0;
          state <= ST_T_RD;
        end
        ST_T_RD: begin
          if (t_idx == num_tracks) begin
            d_idx <= '0;
            state <= ST_N_RD;
          end else begin
            state <= ST_T_LAT;
          end
        end
        ST_T_LAT: begin
          d_idx <= '0;
          found <= 1'b0;
          state <= ST_D_RD;
        end
        ST_D_RD: begin
          if (d_idx == det_fill) begin
            state <= ST_T_END;
          end else if (det_used[d_idx[nnta_pkg::DET_AW-1:0]]) begin
            d_idx <= d_idx + 1'b1;
          end else begin
            state <= ST_D_DIF;
          end
        end
        ST_D_DIF: state <= ST_D_MX;
        ST_D_MX:  state <= ST_D_MY;
        ST_D_MY:  state <= ST_D_CMP;
        ST_D_CMP: begin
          found <= 1'b1;
          d_idx <= d_idx + 1'b1;
          state <= ST_D_RD;
        end
        ST_T_END: begin
          state <= ST_T_RD;
          t_idx <= t_idx + 1'b1;
          if (found && (best_d < {5'd0, gate_sq})) begin
            det_used[best] <= 1'b1;
            if ((best_d >= {13'd0, motion_sq}) && emit_now) begin
              if (!trk.confirmed && (confirmed_count != 16'hFFFF)) begin
                confirmed_count <= confirmed_count + 16'd1;
              end
              t_idx <= t_idx;
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_frame <= frame_counter;
            out_has   <= 1'b1;
            out_id    <= trk.ident;
            out_x     <= best_x;
            out_y     <= best_y;
            out_total <= confirmed_count;
            out_last  <= 1'b0;
            t_idx     <= t_idx + 1'b1;
            state     <= ST_T_RD;
          end
        end
        ST_N_RD: begin
          if (d_idx == det_fill) begin
            t_idx <= '0;
            w_idx <= '0;
            state <= ST_X_RD;
          end else if (det_used[d_idx[nnta_pkg::DET_AW-1:0]]
                       || (num_tracks == nnta_pkg::TRK_CW'(nnta_pkg::MAX_TRACKS))) begin
            d_idx <= d_idx + 1'b1;
          end else begin
            state <= ST_N_WR;
          end
        end
        ST_N_WR: begin
          next_ident <= next_ident + 16'd1;
          num_tracks <= num_tracks + 1'b1;
          d_idx      <= d_idx + 1'b1;
          state      <= ST_N_RD;
        end
        ST_X_RD: begin
          if (t_idx == num_tracks) begin
            state <= ST_CLOSE;
          end else begin
            state <= ST_X_CHK;
          end
        end
        ST_X_CHK: begin
          if (trk_we) begin
            w_idx <= w_idx + 1'b1;
          end
          t_idx <= t_idx + 1'b1;
          state <= ST_X_RD;
        end
        ST_CLOSE: begin
          if (out_free) begin
            out_frame  <= frame_counter;
            out_has    <= 1'b0;
            out_id     <= '0;
            out_x      <= '0;
            out_y      <= '0;
            out_total  <= confirmed_count;
            out_last   <= 1'b1;
            num_tracks <= w_idx;
            det_used   <= '0;
            det_fill   <= '0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid           = out_valid;
  assign res.frame_number    = out_frame;
  assign res.has_track       = out_has;
  assign res.target_id       = out_id;
  assign res.pos_x           = out_x;
  assign res.pos_y           = out_y;
  assign res.confirmed_total = out_total;
  assign res.last_of_frame   = out_last;

endmodule

@@ design/nnta_checker.sv @@
module nnta_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        has_track,
  input logic        last_of_frame,
  input logic [15:0] target_id,
  input logic [15:0] pos_x
);

  // hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // record and closing beat are exclusive
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (has_track != last_of_frame))
    else $error("result beat is neither record nor closing");

  // closing beat carries no track
  a_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_frame |-> (target_id == 16'd0) && (pos_x == 16'd0))
    else $error("closing beat carries track data");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind nearest_neighbor_track_associator_top nnta_checker u_nnta_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .has_track     (res.has_track),
  .last_of_frame (res.last_of_frame),
  .target_id     (res.target_id),
  .pos_x         (res.pos_x)
);
